// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the moving mean square RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/mms_pkg.sv =====
// Package: widths, register codes, defaults and control types of the moving mean square.
`timescale 1ns / 1ps

package mms_pkg;

    // Parameter defaults
    localparam int MAX_WINDOW_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field and state widths
    localparam int LEN_W      = 17;
    localparam int INV_W      = 33;
    localparam int SUM_W      = 63;
    localparam int OUT_W      = 47;
    localparam int HALF_W     = 32;
    localparam int PROD_W     = 64;
    localparam int CFG_DATA_W = 33;
    localparam int CFG_IDX_W  = 1;

    // Register reset values
    localparam int LEN_RESET = 4800;
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(894785);

    // Rounding offset for the Q32 scaling
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h0000_0000_8000_0000);
    localparam logic [OUT_W-1:0]  OUT_MAX    = '1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH  = 1'b0,
        REG_INVERSE_LENGTH = 1'b1
    } mms_reg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // square the sample, read history at write position
        logic update;    // replace history entry, update running sum
        logic mul_lo;    // low partial product of the scaling
        logic mul_hi;    // high partial product of the scaling
        logic load_out;  // saturate and load the output register
    } mms_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_stall; // output register holds an item not yet taken
    } mms_status_t;

endpackage

// ===== rtl/core/mms_ctrl.sv =====
// Controller: sequences one item through square, history update and scaling.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mms_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mms_pkg::mms_status_t  status,
    output mms_pkg::mms_cmd_t     cmd
);
    import mms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_LO   = 5'b00100,
        S_HI   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SUM;
            end
            S_SUM:  state_next = S_LO;
            S_LO:   state_next = S_HI;
            S_HI:   state_next = S_OUT;
            S_OUT: begin
                if (!status.out_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath commands
    always_comb begin
        cmd          = '0;
        cmd.load_in  = accept;
        cmd.update   = (state_reg == S_SUM);
        cmd.mul_lo   = (state_reg == S_LO);
        cmd.mul_hi   = (state_reg == S_HI);
        cmd.load_out = (state_reg == S_OUT) && !status.out_stall;
    end

    `ASSERT_NEXT(a_accept_goes_sum, aclk, aresetn, accept, state_reg == S_SUM, "accepted item did not reach the sum step")
    `ASSERT_NEXT(a_out_returns_idle, aclk, aresetn, cmd.load_out, s_ready, "not ready after result load")

endmodule

// ===== rtl/core/mms_datapath.sv =====
// Datapath: squarer, history memory, running sum, Q32 scaling and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mms_datapath #(
    parameter int MAX_WINDOW  = mms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  logic                               cfg_we,
    input  logic [mms_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [mms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  mms_pkg::mms_cmd_t                  cmd,
    output mms_pkg::mms_status_t               status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mms_pkg::OUT_W-1:0]          m_mean_square
);
    import mms_pkg::*;

    localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SQ_FULL_W = 2 * SAMPLE_BITS;
    localparam int SQ_W      = 2 * SAMPLE_BITS - 1;
    localparam int LEN_RST   = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

    // Configuration and window state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [INV_W-1:0]  inv_reg, inv_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic              wrap_reg, wrap_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [SQ_W-1:0]   rd_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [OUT_W-1:0]  mean_reg, mean_next;

    // History of squares
    logic [SQ_W-1:0]   hist_mem [MAX_WINDOW];

    logic [SAMPLE_BITS-1:0] raw, mag;
    logic [SQ_FULL_W-1:0]   sq_full;
    logic [SQ_W-1:0]        old_sq;
    logic [AW:0]            pos_inc;
    logic [LEN_W-1:0]       len_wr;
    logic [OUT_W:0]         tot;

    // Squarer: magnitude first so the most negative sample squares exactly
    assign raw     = $unsigned(s_sample);
    assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign sq_full = SQ_FULL_W'(mag) * SQ_FULL_W'(mag);
    assign sq_next = sq_full[SQ_W-1:0];

    // Entries not yet written since the last clear read as zero
    assign old_sq  = wrap_reg ? rd_reg : '0;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    // Window length written: zero becomes one, large values clamp
    always_comb begin
        len_wr = cfg_wdata[LEN_W-1:0];
        if (len_wr == '0) begin
            len_wr = LEN_W'(1);
        end else if (32'(len_wr) > 32'(MAX_WINDOW)) begin
            len_wr = LEN_W'(MAX_WINDOW);
        end
    end

    // Window state next values
    always_comb begin
        len_next  = len_reg;
        inv_next  = inv_reg;
        sum_next  = sum_reg;
        pos_next  = pos_reg;
        wrap_next = wrap_reg;
        if (cfg_we && cfg_idx == REG_WINDOW_LENGTH) begin
            len_next  = len_wr;
            sum_next  = '0;
            pos_next  = '0;
            wrap_next = 1'b0;
        end else if (cfg_we && cfg_idx == REG_INVERSE_LENGTH) begin
            inv_next = cfg_wdata[INV_W-1:0];
        end else if (cmd.update) begin
            sum_next = sum_reg - SUM_W'(old_sq) + SUM_W'(sq_reg);
            if (32'(pos_inc) >= 32'(len_reg)) begin
                pos_next  = '0;
                wrap_next = 1'b1;
            end else begin
                pos_next = pos_inc[AW-1:0];
            end
        end
    end

    // Scaling: two partial products of sum * inverse, rounded half up
    always_comb begin
        prod_next = prod_reg;
        if (cmd.mul_lo) begin
            prod_next = PROD_W'(sum_reg[HALF_W-1:0]) * PROD_W'(inv_reg[HALF_W-1:0])
                        + ROUND_HALF;
        end else if (cmd.mul_hi) begin
            prod_next = PROD_W'(sum_reg[SUM_W-1:HALF_W]) * PROD_W'(inv_reg[HALF_W-1:0])
                        + PROD_W'(prod_reg[PROD_W-1:HALF_W]);
        end
    end

    // Top bit of the inverse adds the sum itself; saturate to the output range
    assign tot = (OUT_W + 1)'(prod_reg[OUT_W-1:0]) + (OUT_W + 1)'(sum_reg[OUT_W-1:0]);

    always_comb begin
        priority if (prod_reg > PROD_W'(OUT_MAX)) begin
            mean_next = OUT_MAX;
        end else if (!inv_reg[INV_W-1]) begin
            mean_next = prod_reg[OUT_W-1:0];
        end else if (sum_reg > SUM_W'(OUT_MAX)) begin
            mean_next = OUT_MAX;
        end else if (tot > (OUT_W + 1)'(OUT_MAX)) begin
            mean_next = OUT_MAX;
        end else begin
            mean_next = tot[OUT_W-1:0];
        end
    end

    // Output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_W'(LEN_RST);
            inv_reg     <= INV_RESET;
            sum_reg     <= '0;
            pos_reg     <= '0;
            wrap_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            inv_reg     <= inv_next;
            sum_reg     <= sum_next;
            pos_reg     <= pos_next;
            wrap_reg    <= wrap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sq_reg <= sq_next;
        end
        prod_reg <= prod_next;
        if (cmd.load_out) begin
            mean_reg <= mean_next;
        end
    end

    // History memory: read at accept, write back during the update step
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            rd_reg <= hist_mem[pos_reg];
        end
        if (cmd.update) begin
            hist_mem[pos_reg] <= sq_reg;
        end
    end

    assign status.out_stall = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_mean_square    = mean_reg;

    `ASSERT_ALWAYS(a_pos_in_window, aclk, aresetn, 32'(pos_reg) < 32'(len_reg), "write position outside window")
    `ASSERT_ALWAYS(a_no_overwrite, aclk, aresetn, cmd.load_out |-> !(m_valid_reg && !m_ready), "result overwritten before taken")

endmodule

// ===== rtl/core/moving_mean_square.sv =====
// Top level: sliding-window mean square of signed audio samples.
//
//  channel   direction  ports                          payload
//  s         in         s_valid / s_ready              s_sample (signed, SAMPLE_BITS)
//  m         out        m_valid / m_ready              m_mean_square (unsigned, 47)
//  cfg       in         cfg_we, cfg_idx                cfg_wdata (33)
//
// Steps from the accept to the result load: history read at the accept, history write
// and sum update, the two 32-bit partial products of the Q32 scaling, then saturation.
// The single-port history read-modify-write and the shared scaling path take new items only
// when the last is done. Reset needs no clearing pass: a wrap flag makes entries not yet
// written since the last clear read as zero. A result waiting on m_ready does not
// block the next accept; only a second finished result waits in the last step.
`timescale 1ns / 1ps

module moving_mean_square #(
    parameter int MAX_WINDOW  = mms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mms_pkg::OUT_W-1:0]       m_mean_square,
    input  logic                            cfg_we,
    input  logic [mms_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [mms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mms_pkg::*;

    mms_cmd_t    cmd;
    mms_status_t status;

    mms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mms_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_sample      (s_sample),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_square (m_mean_square)
    );

endmodule
